// ===== hw/rtl/alt_pkg.sv =====
// Package for the accepted login table: widths, codes and the chain token types.
`default_nettype none
package alt_pkg;

  localparam int ENTRIES   = 16;
  localparam int ADDR_BITS = 48;
  localparam int ADDR_W    = 48;
  localparam int KEY_W     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LIVE_W    = 5;
  localparam int TIME_W    = 16;
  localparam int ATT_W     = 32;
  localparam int CID_W     = 32;
  localparam int ST_W      = 3;
  localparam int MODE_W    = 2;

  localparam logic [TIME_W-1:0] KEEP_TIME_RST = TIME_W'(2000);

  localparam logic [MODE_W-1:0] MODE_ACCEPT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  localparam logic [ST_W-1:0] ST_HIT      = 3'd0;
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [ST_W-1:0] ST_MISS     = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_TICK     = 3'd4;

  // request traveling down the cell chain, one cell per cycle
  typedef struct packed {
    logic              active;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  addr;
    logic [ATT_W-1:0]  attempt;
    logic [TIME_W-1:0] dt;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [CID_W-1:0]  client;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [LIVE_W-1:0] live;
  } token_t;

  // update broadcast to the cells at the end of a pass
  typedef struct packed {
    logic              en;
    logic              insert;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] keep;
    logic [KEY_W-1:0]  addr;
    logic [ATT_W-1:0]  attempt;
    logic [CID_W-1:0]  client;
  } wr_t;

endpackage
`default_nettype wire

// ===== hw/rtl/alt_cell.sv =====
// One table entry cell: holds an entry, serves the passing token, takes updates.
`default_nettype none
module alt_cell import alt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire token_t           tok_in,
  input  wire wr_t              wr,
  output token_t                tok_out
);

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  addr_r;
  logic [ATT_W-1:0]  att_r;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [CID_W-1:0]  client_r;
  token_t            tok_r, tok_nxt;
  logic              match;
  logic              lookup;
  logic              sel;

  always_comb begin
    match     = valid_r && (addr_r == tok_in.addr) && (att_r == tok_in.attempt);
    lookup    = (tok_in.mode == MODE_ACCEPT) || (tok_in.mode == MODE_QUERY);
    sel       = wr.en && (wr.idx == cell_idx);
    tok_nxt   = tok_in;
    valid_nxt = valid_r;
    time_nxt  = time_r;
    if (tok_in.active) begin
      if (lookup && match && !tok_in.hit) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.hit_idx = cell_idx;
        tok_nxt.client  = client_r;
      end
      if (!valid_r && !tok_in.free_found) begin
        tok_nxt.free_found = 1'b1;
        tok_nxt.free_idx   = cell_idx;
      end
      if (tok_in.mode == MODE_TICK && valid_r) begin
        if (time_r < tok_in.dt) begin
          valid_nxt = 1'b0;
        end else begin
          time_nxt = time_r - tok_in.dt;
        end
      end
      tok_nxt.live = tok_in.live + LIVE_W'(valid_nxt);
    end
    if (sel) begin
      time_nxt = wr.keep;
      if (wr.insert) begin
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    if (sel && wr.insert) begin
      addr_r   <= wr.addr;
      att_r    <= wr.attempt;
      client_r <= wr.client;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

// ===== hw/rtl/accepted_login_table_with_aging_unit.sv =====
// Top level: accepted login table with aging, built as a chain of entry cells.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | start / busy         | in_mode, in_addr, in_attempt, in_delta_time
//  result   | out_strobe           | out_client_id, out_status, out_live_entries
//  config   | cfg_we               | cfg_wdata (keep_time)
//
// An item enters a head register, then hops one cell per cycle down the
// chain of ENTRIES cells; the update and result are registered at the end.
// The result strobe rises when the result registers are loaded; busy is high
// from acceptance until the strobe, so the unit holds one item at a time,
// and a new item may start in the strobe cycle. Synchronous reset clears
// all entries, the ID counter and sets keep_time to 2000. Results cannot be
// stalled.
`default_nettype none
module accepted_login_table_with_aging_unit import alt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [ADDR_W-1:0] in_addr,
  input  wire logic [ATT_W-1:0]  in_attempt,
  input  wire logic [TIME_W-1:0] in_delta_time,
  output logic                   out_strobe,
  output logic [CID_W-1:0]       out_client_id,
  output logic [ST_W-1:0]        out_status,
  output logic [LIVE_W-1:0]      out_live_entries,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_wdata
);

  token_t            tok [0:ENTRIES];
  token_t            head_r, head_nxt;
  token_t            tok_end;
  wr_t               wr;
  logic              busy_r, busy_nxt;
  logic [TIME_W-1:0] keep_r;
  logic [CID_W-1:0]  id_r, id_nxt, id_inc;
  logic              strobe_r;
  logic [CID_W-1:0]  cid_r, cid_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [LIVE_W-1:0] live_r, live_nxt;
  logic              accept;

  assign accept = start && !busy_r;

  always_comb begin
    head_nxt            = '0;
    head_nxt.active     = accept;
    head_nxt.mode       = in_mode;
    head_nxt.addr       = in_addr[KEY_W-1:0];
    head_nxt.attempt    = in_attempt;
    head_nxt.dt         = in_delta_time;
  end

  assign tok[0]  = head_r;
  assign tok_end = tok[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    alt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .tok_in   (tok[g]),
      .wr       (wr),
      .tok_out  (tok[g+1])
    );
  end

  always_comb begin
    id_inc     = id_r + CID_W'(1);
    id_nxt     = id_r;
    cid_nxt    = '0;
    st_nxt     = ST_MISS;
    live_nxt   = tok_end.live;
    wr         = '0;
    wr.keep    = keep_r;
    wr.addr    = tok_end.addr;
    wr.attempt = tok_end.attempt;
    wr.client  = id_inc;
    busy_nxt   = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (tok_end.active) begin
      busy_nxt = 1'b0;
      unique case (tok_end.mode)
        MODE_ACCEPT: begin
          if (tok_end.hit) begin
            wr.en   = 1'b1;
            wr.idx  = tok_end.hit_idx;
            cid_nxt = tok_end.client;
            st_nxt  = ST_HIT;
          end else if (tok_end.free_found) begin
            wr.en     = 1'b1;
            wr.insert = 1'b1;
            wr.idx    = tok_end.free_idx;
            id_nxt    = id_inc;
            cid_nxt   = id_inc;
            st_nxt    = ST_INSERTED;
            live_nxt  = tok_end.live + LIVE_W'(1);
          end else begin
            st_nxt = ST_FULL;
          end
        end
        MODE_QUERY: st_nxt = tok_end.hit ? ST_HIT : ST_MISS;
        MODE_TICK:  st_nxt = ST_TICK;
        default:    st_nxt = ST_MISS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      busy_r   <= 1'b0;
      keep_r   <= KEEP_TIME_RST;
      id_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      busy_r   <= busy_nxt;
      id_r     <= id_nxt;
      strobe_r <= tok_end.active;
      if (cfg_we) begin
        keep_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_end.active) begin
      cid_r  <= cid_nxt;
      st_r   <= st_nxt;
      live_r <= live_nxt;
    end
  end

  assign busy             = busy_r;
  assign out_strobe       = strobe_r;
  assign out_client_id    = cid_r;
  assign out_status       = st_r;
  assign out_live_entries = live_r;

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> strobe_r)
    else $error("busy dropped without a result");

  a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> !busy_r)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("busy not raised after accept");

  a_end_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.active |-> busy_r)
    else $error("token left the chain with no item in flight");

  a_insert_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && wr.insert) |-> (tok_end.active && !tok_end.hit && tok_end.free_found))
    else $error("insert without a free slot");

endmodule
`default_nettype wire

// ===== sim/accepted_login_table_with_aging_unit_tb.sv =====
// Self-checking testbench for the accepted login table with aging: directed and random traffic.
module accepted_login_table_with_aging_unit_tb;
  import alt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int POOL = 24;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic [CID_W-1:0]  cid;
    logic [ST_W-1:0]   st;
    logic [LIVE_W-1:0] live;
  } login_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   in_mode = '0;
  logic [ADDR_W-1:0]   in_addr = '0;
  logic [ATT_W-1:0]    in_attempt = '0;
  logic [TIME_W-1:0]   in_delta_time = '0;
  logic                out_strobe;
  logic [CID_W-1:0]    out_client_id;
  logic [ST_W-1:0]     out_status;
  logic [LIVE_W-1:0]   out_live_entries;
  logic                cfg_we = 1'b0;
  logic [TIME_W-1:0]   cfg_wdata = '0;

  // login table shadow
  logic                tbl_valid [ENTRIES];
  logic [KEY_W-1:0]    tbl_addr  [ENTRIES];
  logic [ATT_W-1:0]    tbl_att   [ENTRIES];
  logic [TIME_W-1:0]   tbl_left  [ENTRIES];
  logic [CID_W-1:0]    tbl_cid   [ENTRIES];
  logic [CID_W-1:0]    id_ctr = '0;
  logic [TIME_W-1:0]   keep_now = KEEP_TIME_RST;

  login_result_t       login_q[$];
  login_result_t       due;
  logic [ADDR_W-1:0]   pool_addr [POOL];
  logic [ATT_W-1:0]    pool_att  [POOL];

  int err_count = 0;
  int idle_cycles = 0;
  int n_items = 0, n_checked = 0, n_cfg = 0;
  int n_hit = 0, n_ins = 0, n_miss = 0, n_full = 0, n_tick = 0;
  bit calm = 1'b0;

  accepted_login_table_with_aging_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_addr          (in_addr),
    .in_attempt       (in_attempt),
    .in_delta_time    (in_delta_time),
    .out_strobe       (out_strobe),
    .out_client_id    (out_client_id),
    .out_status       (out_status),
    .out_live_entries (out_live_entries),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic login_result_t table_apply(logic [MODE_W-1:0] mode,
                                                logic [ADDR_W-1:0] a,
                                                logic [ATT_W-1:0] att,
                                                logic [TIME_W-1:0] dt);
    login_result_t r;
    logic [KEY_W-1:0] key_a;
    int hit_k;
    int free_k;
    int k;
    key_a = a[KEY_W-1:0];
    r = '0;
    r.st = ST_MISS;
    hit_k = -1;
    free_k = -1;
    for (k = 0; k < ENTRIES; k++) begin
      if (tbl_valid[k] && tbl_addr[k] == key_a && tbl_att[k] == att && hit_k < 0) hit_k = k;
      if (!tbl_valid[k] && free_k < 0) free_k = k;
    end
    case (mode)
      MODE_ACCEPT: begin
        if (hit_k >= 0) begin
          tbl_left[hit_k] = keep_now;
          r.cid = tbl_cid[hit_k];
          r.st = ST_HIT;
        end else if (free_k < 0) begin
          r.st = ST_FULL;
        end else begin
          id_ctr = id_ctr + 1'b1;
          tbl_valid[free_k] = 1'b1;
          tbl_addr[free_k] = key_a;
          tbl_att[free_k] = att;
          tbl_left[free_k] = keep_now;
          tbl_cid[free_k] = id_ctr;
          r.cid = id_ctr;
          r.st = ST_INSERTED;
        end
      end
      MODE_QUERY: r.st = (hit_k >= 0) ? ST_HIT : ST_MISS;
      MODE_TICK: begin
        for (k = 0; k < ENTRIES; k++) begin
          if (tbl_valid[k]) begin
            if (tbl_left[k] < dt) tbl_valid[k] = 1'b0;
            else tbl_left[k] = tbl_left[k] - dt;
          end
        end
        r.st = ST_TICK;
      end
      default: ;
    endcase
    for (k = 0; k < ENTRIES; k++) r.live = r.live + LIVE_W'(tbl_valid[k]);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    err_count++;
    if (err_count <= 40)
      $display("%0t ns mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, exp);
  endtask

  task automatic send_item(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] a,
                           logic [ATT_W-1:0] att, logic [TIME_W-1:0] dt);
    login_result_t r;
    int gap;
    int pick;
    @(negedge clk);
    start <= 1'b1;
    in_mode <= mode;
    in_addr <= a;
    in_attempt <= att;
    in_delta_time <= dt;
    do @(posedge clk); while (busy);
    r = table_apply(mode, a, att, dt);
    login_q = {login_q, r};
    n_items++;
    case (r.st)
      ST_HIT:      n_hit++;
      ST_INSERTED: n_ins++;
      ST_FULL:     n_full++;
      ST_TICK:     n_tick++;
      default:     n_miss++;
    endcase
    @(negedge clk);
    start <= 1'b0;
    in_mode <= MODE_W'($urandom);
    in_addr <= ADDR_W'({$urandom, $urandom});
    in_attempt <= $urandom;
    in_delta_time <= TIME_W'($urandom);
    if ($urandom_range(0, 49) == 0) calm = !calm;
    pick = $urandom_range(0, 99);
    if (calm || pick < 45) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 19);
    else gap = $urandom_range(20, 60);
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain;
    while (login_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(logic [TIME_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= TIME_W'($urandom);
    keep_now = v;
    n_cfg++;
  endtask

  task automatic make_pool;
    int p;
    for (p = 0; p < POOL; p++) begin
      pool_addr[p] = ADDR_W'({$urandom, $urandom});
      pool_att[p] = $urandom;
      // near misses: same address with another attempt, or the reverse
      if (p > 0 && $urandom_range(0, 3) == 0) pool_addr[p] = pool_addr[p-1];
      else if (p > 0 && $urandom_range(0, 3) == 0) pool_att[p] = pool_att[p-1];
    end
  endtask

  task automatic test_directed;
    send_item(MODE_QUERY, '1, '1, '0);
    send_item(MODE_ACCEPT, '1, '1, '0);
    send_item(MODE_ACCEPT, '1, '1, '1);
    send_item(MODE_QUERY, '1, '1, '0);
    send_item(MODE_ACCEPT, '0, '0, '0);
    send_item(MODE_ACCEPT, '1, '0, '0);
    send_item(MODE_ACCEPT, '0, '1, '0);
    send_item(MODE_UNUSED, '1, '1, '1);
    send_item(MODE_TICK, '0, '0, 16'd0);
    send_item(MODE_TICK, '1, '1, 16'd1999);
    send_item(MODE_ACCEPT, '1, '1, '0);
    send_item(MODE_TICK, '0, '0, 16'd1);
    send_item(MODE_TICK, '0, '0, 16'd1);
    send_item(MODE_QUERY, '0, '0, '0);
    send_item(MODE_ACCEPT, '0, '0, '0);
    send_item(MODE_TICK, '0, '0, '1);
    send_item(MODE_ACCEPT, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 16'hAAAA);
    send_item(MODE_ACCEPT, 48'h5555_5555_5555, 32'hAAAA_AAAA, 16'h5555);
    send_item(MODE_QUERY, 48'h2AAA_AAAA_AAAA, 32'h5555_5555, '0);
  endtask

  task automatic test_full_table;
    int k;
    cfg_write('1);
    make_pool();
    send_item(MODE_TICK, '0, '0, '1);
    send_item(MODE_TICK, '0, '0, '1);
    for (k = 0; k <= ENTRIES; k++) send_item(MODE_ACCEPT, pool_addr[k], pool_att[k], '0);
    send_item(MODE_ACCEPT, pool_addr[3], pool_att[3], '0);
    send_item(MODE_QUERY, pool_addr[ENTRIES], pool_att[ENTRIES], '0);
    send_item(MODE_TICK, '0, '0, '1);
    send_item(MODE_ACCEPT, pool_addr[ENTRIES], pool_att[ENTRIES], '0);
  endtask

  task automatic test_aging(logic [TIME_W-1:0] keep, int n, int tick_pct, int dt_max);
    int i;
    int r;
    int p;
    logic [TIME_W-1:0] dt;
    cfg_write(keep);
    make_pool();
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, POOL - 1);
      if (r < tick_pct) begin
        case ($urandom_range(0, 9))
          0:       dt = '0;
          1:       dt = keep_now;
          2:       dt = keep_now + 1'b1;
          3:       dt = '1;
          default: dt = TIME_W'($urandom_range(0, dt_max));
        endcase
        send_item(MODE_TICK, ADDR_W'({$urandom, $urandom}), $urandom, dt);
      end else if (r < tick_pct + 50) begin
        send_item(MODE_ACCEPT, pool_addr[p], pool_att[p], TIME_W'($urandom));
      end else if (r < tick_pct + 68) begin
        send_item(MODE_QUERY, pool_addr[p], pool_att[p], TIME_W'($urandom));
      end else if (r < tick_pct + 80) begin
        send_item(MODE_ACCEPT, ADDR_W'({$urandom, $urandom}), $urandom, TIME_W'($urandom));
      end else if (r < tick_pct + 92) begin
        send_item(MODE_QUERY, ADDR_W'({$urandom, $urandom}), $urandom, TIME_W'($urandom));
      end else begin
        send_item(MODE_UNUSED, pool_addr[p], pool_att[p], TIME_W'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (login_q.size() == 0) begin
        report_mismatch("result with nothing pending, status", 64'(out_status), '0);
      end else begin
        due = login_q.pop_front();
        n_checked++;
        if (out_client_id !== due.cid)
          report_mismatch("client_id", 64'(out_client_id), 64'(due.cid));
        if (out_status !== due.st) report_mismatch("status", 64'(out_status), 64'(due.st));
        if (out_live_entries !== due.live)
          report_mismatch("live_entries", 64'(out_live_entries), 64'(due.live));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item or result for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    for (k = 0; k < ENTRIES; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_addr[k] = '0;
      tbl_att[k] = '0;
      tbl_left[k] = '0;
      tbl_cid[k] = '0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_table();
    test_aging(16'd2000, 300, 10, 400);
    test_aging(16'd1, 200, 20, 2);
    test_aging(16'd0, 150, 15, 1);
    test_aging(16'hFFFF, 300, 4, 3000);
    test_aging(TIME_W'($urandom_range(1, 65535)), 250, 8, $urandom_range(1, 8000));
    drain();
    repeat (ENTRIES + 4) @(posedge clk);
    if (login_q.size() != 0)
      report_mismatch("results never delivered", 64'(login_q.size()), 64'(0));
    $display("Sent %0d items: %0d inserts, %0d hits, %0d misses, %0d full refusals, %0d ticks",
             n_items, n_ins, n_hit, n_miss, n_full, n_tick);
    $display("Checked %0d results across %0d keep_time writes, %0d mismatches",
             n_checked, n_cfg, err_count);
    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
